FILE: rtl/core/dcd_pkg.sv
// dcd_pkg: shared widths, limits and pipeline word type for the decimal counter display
// no dependencies; every other file takes names from here by scope
package dcd_pkg;

   // number of decimal digits the counter is allowed to use, 1 .. 8
   localparam int NUM_DIGITS = 8;

   localparam int DISPLAY_DIGITS = 8;
   localparam int AMOUNT_BITS = 28;
   localparam int COUNTER_BITS = 27;
   localparam int BCD_BITS = 4 * DISPLAY_DIGITS;
   localparam int COUNT_BITS = 4;

   // double dabble: binary shifted in from the top, padded to a whole number of stages
   localparam int STEPS_PER_STAGE = 7;
   localparam int NUM_STAGES = (COUNTER_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int BIN_BITS = NUM_STAGES * STEPS_PER_STAGE;

   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 72;

   // largest value the counter may hold: 10^min(NUM_DIGITS, DISPLAY_DIGITS) - 1
   function automatic logic [COUNTER_BITS-1:0] calc_limit();
      int lim;
      lim = 1;
      for (int i = 0; i < NUM_DIGITS && i < DISPLAY_DIGITS; i++) begin
         lim = lim * 10;
      end
      return COUNTER_BITS'(lim - 1);
   endfunction

   localparam logic [COUNTER_BITS-1:0] COUNT_LIMIT = calc_limit();

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ADD  = 1'b1;

   // one word moving down the conversion pipeline
   typedef struct packed {
      logic [BCD_BITS-1:0]     bcd;    // digits built so far, digit 7 on top
      logic [BIN_BITS-1:0]     bin;    // binary bits still to shift in, msb first
      logic [COUNTER_BITS-1:0] value;  // clamped counter value carried along
   } work_type;

endpackage

FILE: rtl/core/dcd_update.sv
// dcd_update: counter register with load / signed add and clamp to the display limit
// depends on dcd_pkg for widths, limit, operation codes and work_type
module dcd_update (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   input  logic                              up_operation,
   input  logic [dcd_pkg::AMOUNT_BITS-1:0]   up_amount,
   output logic                              up_ready,
   output logic                              dn_valid,
   output dcd_pkg::work_type                 dn_work,
   input  logic                              dn_ready
);

   logic                                 valid_ff, valid_in;
   logic [dcd_pkg::COUNTER_BITS-1:0]     cnt_ff, cnt_in;
   logic signed [dcd_pkg::AMOUNT_BITS:0] amt_ext, cnt_ext, sum;
   logic                                 take;

   assign up_ready = !valid_ff || dn_ready;
   assign take     = up_valid && up_ready;

   always_comb begin
      amt_ext = $signed({up_amount[dcd_pkg::AMOUNT_BITS-1], up_amount});
      cnt_ext = $signed({2'b00, cnt_ff});
      sum = (up_operation == dcd_pkg::OP_ADD) ? (cnt_ext + amt_ext) : amt_ext;
      if (sum < 0) begin
         cnt_in = '0;
      end else if (sum > $signed({2'b00, dcd_pkg::COUNT_LIMIT})) begin
         cnt_in = dcd_pkg::COUNT_LIMIT;
      end else begin
         cnt_in = sum[dcd_pkg::COUNTER_BITS-1:0];
      end
   end

   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   assign dn_valid = valid_ff;

   always_comb begin
      dn_work       = '0;
      dn_work.bin   = dcd_pkg::BIN_BITS'(cnt_ff);
      dn_work.value = cnt_ff;
   end

endmodule

FILE: rtl/core/dcd_dabble_stage.sv
// dcd_dabble_stage: one registered stage of shift-and-add-3 binary to bcd conversion
// depends on dcd_pkg for step count, widths and work_type
module dcd_dabble_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   input  dcd_pkg::work_type up_work,
   output logic              up_ready,
   output logic              dn_valid,
   output dcd_pkg::work_type dn_work,
   input  logic              dn_ready
);

   logic              valid_ff, valid_in;
   dcd_pkg::work_type work_ff, work_in;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      logic [dcd_pkg::BCD_BITS-1:0] bcd_v;
      logic [dcd_pkg::BIN_BITS-1:0] bin_v;
      bcd_v = up_work.bcd;
      bin_v = up_work.bin;
      for (int s = 0; s < dcd_pkg::STEPS_PER_STAGE; s++) begin
         // digits of five or more get three added before the doubling
         for (int d = 0; d < dcd_pkg::DISPLAY_DIGITS; d++) begin
            if (bcd_v[4*d +: 4] >= 4'd5) begin
               bcd_v[4*d +: 4] = bcd_v[4*d +: 4] + 4'd3;
            end
         end
         {bcd_v, bin_v} = {bcd_v[dcd_pkg::BCD_BITS-2:0], bin_v, 1'b0};
      end
      work_in.bcd   = bcd_v;
      work_in.bin   = bin_v;
      work_in.value = up_work.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         work_ff <= work_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_work  = work_ff;

endmodule

FILE: rtl/core/dcd_format.sv
// dcd_format: significant digit count, blanking mask and the result register
// depends on dcd_pkg for widths and work_type
module dcd_format (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   input  dcd_pkg::work_type                   up_work,
   output logic                                up_ready,
   output logic                                rsp_tvalid,
   output logic [dcd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                rsp_tready
);

   logic                                valid_ff, valid_in;
   logic [dcd_pkg::RSP_DATA_BITS-1:0]   data_ff, data_in;
   logic [dcd_pkg::COUNT_BITS-1:0]      count;
   logic [dcd_pkg::DISPLAY_DIGITS-1:0]  mask;

   assign up_ready = !valid_ff || rsp_tready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      // highest nonzero digit sets the count, zero still shows one digit
      count = dcd_pkg::COUNT_BITS'(1);
      for (int d = 0; d < dcd_pkg::DISPLAY_DIGITS; d++) begin
         if (up_work.bcd[4*d +: 4] != 4'd0) begin
            count = dcd_pkg::COUNT_BITS'(d + 1);
         end
      end
      mask = dcd_pkg::DISPLAY_DIGITS'((9'd1 << count) - 9'd1);
   end

   always_comb begin
      data_in = '0;
      for (int d = 0; d < dcd_pkg::DISPLAY_DIGITS; d++) begin
         // digit 7 in the lowest nibble, digit 0 last
         data_in[4*d +: 4] = up_work.bcd[4*(dcd_pkg::DISPLAY_DIGITS-1-d) +: 4];
      end
      data_in[dcd_pkg::BCD_BITS +: dcd_pkg::COUNT_BITS] = count;
      data_in[dcd_pkg::BCD_BITS + dcd_pkg::COUNT_BITS +: dcd_pkg::DISPLAY_DIGITS] = mask;
      data_in[dcd_pkg::BCD_BITS + dcd_pkg::COUNT_BITS + dcd_pkg::DISPLAY_DIGITS +:
              dcd_pkg::COUNTER_BITS] = up_work.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

FILE: rtl/core/decimal_counter_display_digits.sv
// decimal_counter_display_digits: top level of the clamped decimal counter with digit display
// depends on dcd_pkg, dcd_update, dcd_dabble_stage and dcd_format
//
// channel  dir  handshake           payload
// req      in   req_tvalid/tready   tuser: operation, tdata: amount
// rsp      out  rsp_tvalid/tready   tdata: digits, significant count, mask, counter value
//
// one word accepted per cycle unless the result stream stalls, one result word per accepted word, in order
// each word passes the counter update, 4 shift-and-add-3 stages and the result register
// throughput is set by the counter update, a single add and clamp fed back for each accepted word
// synchronous reset clears the counter to zero and empties every stage
// each stage holds its word while the next one is full, bubbles close up under stall
module decimal_counter_display_digits (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dcd_pkg::REQ_DATA_BITS-1:0]   req_tdata,   // [27:0] amount, [31:28] zero
   input  logic                                req_tuser,   // [0] operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dcd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata    // [3:0] digit_7 .. [31:28] digit_0,
                                                            // [35:32] significant_count,
                                                            // [43:36] shown_mask,
                                                            // [70:44] counter_value, [71] zero
);

   // stage handshakes, index 0 is the counter update output
   logic              stg_valid [dcd_pkg::NUM_STAGES+1];
   logic              stg_ready [dcd_pkg::NUM_STAGES+1];
   dcd_pkg::work_type stg_work  [dcd_pkg::NUM_STAGES+1];

   // load or add, then clamp; the stage register doubles as the counter state
   dcd_update u_update (
      .clock        (clock),
      .reset        (reset),
      .up_valid     (req_tvalid),
      .up_operation (req_tuser),
      .up_amount    (req_tdata[dcd_pkg::AMOUNT_BITS-1:0]),
      .up_ready     (req_tready),
      .dn_valid     (stg_valid[0]),
      .dn_work      (stg_work[0]),
      .dn_ready     (stg_ready[0])
   );

   // binary to bcd, a fixed number of shift steps per stage
   for (genvar g = 0; g < dcd_pkg::NUM_STAGES; g++) begin : g_dabble
      dcd_dabble_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[g]),
         .up_work  (stg_work[g]),
         .up_ready (stg_ready[g]),
         .dn_valid (stg_valid[g+1]),
         .dn_work  (stg_work[g+1]),
         .dn_ready (stg_ready[g+1])
      );
   end

   // leading zero blanking and the result register
   dcd_format u_format (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (stg_valid[dcd_pkg::NUM_STAGES]),
      .up_work    (stg_work[dcd_pkg::NUM_STAGES]),
      .up_ready   (stg_ready[dcd_pkg::NUM_STAGES]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tready (rsp_tready)
   );

endmodule

FILE: bench/dcd_display_checker.sv
// dcd_display_checker: watches both streams of the decimal counter display, keeps its own
// copy of the counter, predicts each result word and compares it field by field
// depends on dcd_pkg for the digit count, the request and result widths and the operation code
module dcd_display_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [dcd_pkg::REQ_DATA_BITS-1:0]  req_tdata,   // [27:0] amount, [31:28] zero
   input  logic                               req_tuser,   // [0] operation
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [dcd_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,   // [31:0] digit_7 .. digit_0,
                                                           // [35:32] significant_count,
                                                           // [43:36] shown_mask,
                                                           // [70:44] counter_value, [71] zero
   output int                                 failures,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // same bit order as the result bus
   typedef struct packed {
      logic        pad;
      logic [26:0] value;
      logic [7:0]  mask;
      logic [3:0]  sig_count;
      logic [31:0] digits;     // digit_7 in [3:0], digit_0 in [31:28]
   } display_word_type;

   display_word_type due_displays[$];
   display_word_type got_word;
   display_word_type want_word;
   logic [26:0]      tally;
   int               fail_tally = 0;
   int               due_count = 0;

   assign failures = fail_tally;
   assign pending  = due_count;

   // largest value allowed: 10^min(digits, 8) - 1
   function automatic longint tally_ceiling();
      longint lim;
      lim = 1;
      for (int i = 0; i < dcd_pkg::NUM_DIGITS && i < 8; i++) begin
         lim = lim * 10;
      end
      return lim - 1;
   endfunction

   function automatic logic [26:0] next_tally(input logic [26:0] now, input logic op,
                                              input logic [27:0] raw);
      longint amt;
      longint sum;
      amt = $signed(raw);
      if (op == dcd_pkg::OP_ADD) begin
         sum = longint'(now) + amt;
      end else begin
         sum = amt;
      end
      if (sum < 0) sum = 0;
      if (sum > tally_ceiling()) sum = tally_ceiling();
      if (sum > 99999999) sum = 99999999;
      return sum[26:0];
   endfunction

   function automatic display_word_type display_of(input logic [26:0] v);
      display_word_type w;
      int unsigned      rest;
      int unsigned      place;
      int unsigned      d;
      int unsigned      n;
      w = '0;
      rest = v;
      place = 10000000;
      for (int i = 0; i < 8; i++) begin
         d = rest / place;
         rest = rest - d * place;
         w.digits[4*i +: 4] = d[3:0];
         place = place / 10;
      end
      n = 0;
      rest = v;
      while (rest != 0) begin
         rest = rest / 10;
         n++;
      end
      if (n == 0) n = 1;
      w.sig_count = n[3:0];
      w.mask = 8'((1 << n) - 1);
      w.value = v;
      return w;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tally = '0;
         due_displays.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_word = rsp_tdata;
            if (due_displays.size() == 0) begin
               $display("%0t ns: result word with none expected, expected none actual %h",
                        $time, rsp_tdata);
               fail_tally++;
            end else begin
               want_word = due_displays.pop_front();
               for (int i = 0; i < 8; i++) begin
                  check_field($sformatf("digit_%0d", 7 - i), want_word.digits[4*i +: 4],
                              got_word.digits[4*i +: 4]);
               end
               check_field("significant_count", want_word.sig_count, got_word.sig_count);
               check_field("shown_mask", want_word.mask, got_word.mask);
               check_field("counter_value", want_word.value, got_word.value);
               check_field("pad bit", want_word.pad, got_word.pad);
            end
         end
         if (req_tvalid && req_tready) begin
            tally = next_tally(tally, req_tuser, req_tdata[27:0]);
            due_displays.push_back(display_of(tally));
         end
      end
      due_count = due_displays.size();
   end

endmodule

FILE: bench/tb_top.sv
// tb_top: stimulus, clocking and verdict for the decimal counter display block
// depends on dcd_pkg, the block itself and dcd_display_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 1000;   // longest correct quiet spell is the long receiver hold
   localparam int RANDOM_WORDS = 1030;
   localparam int HOLD_AFTER = 300;     // words sent before the long receiver hold
   localparam int HOLD_CYCLES = 150;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [dcd_pkg::REQ_DATA_BITS-1:0]  req_tdata = '0;    // [27:0] amount, [31:28] zero
   logic                               req_tuser = 1'b0;  // [0] operation
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [dcd_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;         // [31:0] digit_7 .. digit_0,
                                                          // [35:32] significant_count,
                                                          // [43:36] shown_mask,
                                                          // [70:44] counter_value, [71] zero
   int                                 failures;
   int                                 pending;
   int                                 words_sent = 0;
   bit                                 calm = 1'b0;       // no idling on either side

   // free running clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   decimal_counter_display_digits dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dcd_display_checker display_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   function automatic int ten_to(input int unsigned k);
      int p;
      p = 1;
      repeat (k) p = p * 10;
      return p;
   endfunction

   // one word on the request stream; called at a falling edge, returns at a falling edge
   // with tvalid still high, so back to back words drop it only for an inserted random gap
   task automatic offer_word(input logic op, input int amt);
      int gap;
      if (!calm && $urandom_range(0, 99) < 15) begin
         gap = $urandom_range(1, 2);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser = op;
      req_tdata = {4'b0000, amt[27:0]};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // amount mix: small steps for adds, values near powers of ten, random digit lengths,
   // anything in the stated range, and raw 28-bit patterns
   function automatic int pick_amount(input logic op);
      int unsigned pick;
      int unsigned k;
      int          val;
      pick = $urandom_range(0, 99);
      if (op == dcd_pkg::OP_ADD && pick < 40) begin
         val = int'($urandom_range(0, 2000)) - 1000;
      end else if (pick < 55) begin
         k = $urandom_range(0, 8);
         val = ten_to(k) + int'($urandom_range(0, 4)) - 2;
         if (op == dcd_pkg::OP_ADD && $urandom_range(0, 1)) val = -val;
      end else if (pick < 78) begin
         k = $urandom_range(1, 8);
         val = int'($urandom_range(0, ten_to(k) - 1));
         if (op == dcd_pkg::OP_ADD && $urandom_range(0, 2) == 0) val = -val;
      end else if (pick < 90) begin
         val = int'($urandom_range(0, 199999998)) - 99999999;
      end else begin
         val = int'($urandom());
      end
      return val;
   endfunction

   // receiver: random stalls, one long hold once the stream is going so the
   // pipeline fills and req_tready drops
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && words_sent >= HOLD_AFTER) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = calm || ($urandom_range(0, 99) >= 15);
         end
      end
   end

   // watchdog on cycles with no word moving on either stream
   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall = 0;
         end else begin
            stall++;
         end
      end
      $display("%0t ns: no word accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic op;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: clamps at both ends, extremes of the 28-bit field, digit count edges
      offer_word(dcd_pkg::OP_LOAD, 0);
      offer_word(dcd_pkg::OP_LOAD, 99999999);
      offer_word(dcd_pkg::OP_LOAD, 100000000);     // overflow on load
      offer_word(dcd_pkg::OP_LOAD, -1);            // negative load
      offer_word(dcd_pkg::OP_LOAD, 'h7FFFFFF);     // largest 28-bit pattern
      offer_word(dcd_pkg::OP_LOAD, 'h8000000);     // most negative 28-bit pattern
      offer_word(dcd_pkg::OP_ADD, 1);
      offer_word(dcd_pkg::OP_ADD, -2);             // add goes below zero
      offer_word(dcd_pkg::OP_LOAD, 99999998);
      offer_word(dcd_pkg::OP_ADD, 1);
      offer_word(dcd_pkg::OP_ADD, 1);              // add goes over the limit
      offer_word(dcd_pkg::OP_ADD, -99999999);
      offer_word(dcd_pkg::OP_LOAD, 12345678);
      offer_word(dcd_pkg::OP_ADD, -12345679);
      offer_word(dcd_pkg::OP_LOAD, 9);
      offer_word(dcd_pkg::OP_ADD, 1);              // 9 -> 10, one more digit
      offer_word(dcd_pkg::OP_LOAD, 99);
      offer_word(dcd_pkg::OP_LOAD, 100);
      offer_word(dcd_pkg::OP_LOAD, 9999999);
      offer_word(dcd_pkg::OP_ADD, 1);              // seven digits to eight
      offer_word(dcd_pkg::OP_LOAD, 1000000);
      offer_word(dcd_pkg::OP_ADD, 'h7FFFFFF);      // raw pattern used as an add
      offer_word(dcd_pkg::OP_ADD, 'h8000000);
      offer_word(dcd_pkg::OP_LOAD, 87654321);

      // random part, with a stretch where neither side idles
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm = (n >= 600 && n < 800);
         op = ($urandom_range(0, 99) < 60) ? dcd_pkg::OP_ADD : dcd_pkg::OP_LOAD;
         offer_word(op, pick_amount(op));
      end
      calm = 1'b0;
      req_tvalid = 1'b0;

      // drain, then keep watching for stray words
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
